### rtl/puct_pkg.sv
package puct_pkg;

	localparam int MAX_CHILDREN_DEF = 64;

	localparam int DIV_NW = 41;
	localparam int DIV_DW = 20;
	localparam int SQ_XW  = 40;
	localparam int SQ_RW  = 20;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_APPLY  = 2'd1;
	localparam logic [1:0] KIND_REVERT = 2'd2;
	localparam logic [1:0] KIND_SELECT = 2'd3;

	localparam logic [1:0] REG_CHILD_COUNT  = 2'd0;
	localparam logic [1:0] REG_LOSS_STEP    = 2'd1;
	localparam logic [1:0] REG_EXPLORE_INIT = 2'd2;
	localparam logic [1:0] REG_EXPLORE_BASE = 2'd3;

	localparam logic [6:0]  CHILD_COUNT_RST  = 7'd0;
	localparam logic [15:0] LOSS_STEP_RST    = 16'd0;
	localparam logic [15:0] EXPLORE_INIT_RST = 16'd640;
	localparam logic [19:0] EXPLORE_BASE_RST = 20'd19652;

	localparam logic [15:0] LN2_Q16    = 16'd45426;
	localparam logic [23:0] PARENT_MAX = 24'hFFFFFF;
	localparam logic [15:0] VISIT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic signed [31:0] mean;
		logic signed [31:0] value;
		logic [15:0]        visits;
		logic [15:0]        prior;
	} entry_t;

	function automatic logic [16:0] ln_tab(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0:    v = 17'd0;
			5'd1:    v = 17'd3973;
			5'd2:    v = 17'd7719;
			5'd3:    v = 17'd11262;
			5'd4:    v = 17'd14624;
			5'd5:    v = 17'd17821;
			5'd6:    v = 17'd20870;
			5'd7:    v = 17'd23783;
			5'd8:    v = 17'd26573;
			5'd9:    v = 17'd29248;
			5'd10:   v = 17'd31818;
			5'd11:   v = 17'd34292;
			5'd12:   v = 17'd36675;
			5'd13:   v = 17'd38975;
			5'd14:   v = 17'd41196;
			5'd15:   v = 17'd43345;
			5'd16:   v = 17'd45426;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/puct_child_select.sv
// load: 41-step mean divide; apply/revert: entry read and update, then the 41-step mean divide
// select: k log normalize shifts (up to 24), n children scanned
// (41-step setup divide with sqrt alongside, then read, multiply, 41-step divide per child)
// one item in flight; next beat taken the cycle after the result registers, plus any wait
// asynchronous reset clears control and the parent count, sets registers to defaults; child table undefined
module puct_child_select
	import puct_pkg::*;
#(
	parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// child_index, prior, value_total, visit_count, parent_visits, pad
	input  logic [95:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// best_index, parent_count, pad
	output logic [31:0] m_tdata,
	// found
	output logic [0:0]  m_tuser,
	input  logic        wr_en,
	input  logic [1:0]  wr_addr,
	input  logic [19:0] wr_data
);

	localparam int AW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
	localparam int SCAN_MAX = (MAX_CHILDREN < 64) ? MAX_CHILDREN : 64;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_MST  = 4'd3;
	localparam logic [3:0] ST_MWT  = 4'd4;
	localparam logic [3:0] ST_FIN  = 4'd5;
	localparam logic [3:0] ST_SST  = 4'd6;
	localparam logic [3:0] ST_SW   = 4'd7;
	localparam logic [3:0] ST_LOG  = 4'd8;
	localparam logic [3:0] ST_LN   = 4'd9;
	localparam logic [3:0] ST_MUL  = 4'd10;
	localparam logic [3:0] ST_SRD  = 4'd11;
	localparam logic [3:0] ST_SPR  = 4'd12;
	localparam logic [3:0] ST_SDS  = 4'd13;
	localparam logic [3:0] ST_SDW  = 4'd14;

	logic [3:0]  state_q;
	logic [6:0]  child_count_q;
	logic [15:0] loss_step_q;
	logic [15:0] explore_init_q;
	logic [19:0] explore_base_q;
	logic [23:0] parent_q;

	logic [1:0]  kind_q;
	logic [5:0]  ci_q;
	entry_t      ent_q;
	logic [6:0]  cnt_q;
	logic        found_q;
	logic [5:0]  best_q;
	logic signed [39:0] best_score_q;
	logic [40:0] r_q;
	logic [4:0]  k_q;
	logic [24:0] c_q;
	logic [44:0] csq_q;
	logic [60:0] t_q;

	logic        out_valid_q;
	logic [5:0]  out_best_q;
	logic        out_found_q;
	logic [23:0] out_parent_q;

	entry_t      mem [MAX_CHILDREN];
	entry_t      rd_q;
	logic        mem_we;
	logic        mem_re;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;

	logic              div_start;
	logic [DIV_NW-1:0] div_n;
	logic [DIV_DW-1:0] div_d;
	logic              div_busy;
	logic [DIV_NW-1:0] div_q;
	logic              sq_start;
	logic              sq_busy;
	logic [SQ_RW-1:0]  sq_root;

	logic        accept;
	logic        fin_go;
	logic [5:0]  in_ci;
	logic [8:0]  in_ci9;
	logic [8:0]  ci9;
	logic [8:0]  cnt9;
	logic        in_ok;
	logic [6:0]  scan_n;
	logic [19:0] base_eff;
	logic [31:0] mag;
	logic [31:0] q32;
	logic signed [31:0] mean_new;
	logic signed [33:0] vsum;
	logic signed [31:0] vclamp;
	logic [16:0] t0;
	logic [16:0] t1;
	logic [11:0] tdiff;
	logic [23:0] tprod;
	logic [20:0] ln_val;
	logic signed [39:0] score;

	puct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (div_q)
	);

	puct_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({parent_q, 16'b0}),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign in_ci    = s_tdata[5:0];
	assign in_ci9   = {3'b0, in_ci};
	assign in_ok    = in_ci9 < 9'(MAX_CHILDREN);
	assign ci9      = {3'b0, ci_q};
	assign cnt9     = {2'b0, cnt_q};
	assign scan_n   = (child_count_q > 7'(SCAN_MAX)) ? 7'(SCAN_MAX) : child_count_q;
	assign base_eff = (explore_base_q == 20'd0) ? 20'd1 : explore_base_q;

	// mean of the working entry
	assign mag      = ent_q.value[31] ? (32'd0 - ent_q.value) : ent_q.value;
	assign q32      = div_q[31:0];
	assign mean_new = ent_q.value[31] ? (32'sd0 - $signed(q32)) : $signed(q32);

	// virtual loss with clamp
	always_comb begin
		if (kind_q == KIND_APPLY) begin
			vsum = {{2{rd_q.value[31]}}, rd_q.value} - $signed({18'b0, loss_step_q});
		end else begin
			vsum = {{2{rd_q.value[31]}}, rd_q.value} + $signed({18'b0, loss_step_q});
		end
		if (vsum[33:31] == 3'b000 || vsum[33:31] == 3'b111) begin
			vclamp = vsum[31:0];
		end else if (vsum[33]) begin
			vclamp = 32'sh80000000;
		end else begin
			vclamp = 32'sh7FFFFFFF;
		end
	end

	// log interpolation, r_q normalized to [1,2)
	assign t0     = ln_tab({1'b0, r_q[15:12]});
	assign t1     = ln_tab(5'({1'b0, r_q[15:12]} + 5'd1));
	assign tdiff  = 12'(t1 - t0);
	assign tprod  = tdiff * r_q[11:0];
	assign ln_val = 21'(k_q) * 21'(LN2_Q16) + 21'(t0) + 21'(tprod[23:12]);

	assign score = 40'(rd_q.mean) + $signed({3'b0, div_q[36:0]});

	always_comb begin
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		sq_start  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = ci9[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				mem_raddr = in_ci9[AW-1:0];
				mem_re    = accept && in_ok &&
					(s_tuser == KIND_APPLY || s_tuser == KIND_REVERT);
			end
			ST_MST: begin
				div_start = 1'b1;
				div_n     = {9'b0, mag};
				div_d     = 20'({1'b0, ent_q.visits} + 17'd1);
			end
			ST_SST: begin
				div_start = 1'b1;
				div_n     = {(25'(parent_q) + 25'(base_eff) + 25'd1), 16'b0};
				div_d     = base_eff;
				sq_start  = 1'b1;
			end
			ST_SRD: begin
				mem_raddr = cnt9[AW-1:0];
				mem_re    = (cnt_q != scan_n);
			end
			ST_SDS: begin
				div_start = 1'b1;
				div_n     = {4'b0, t_q[60:24]};
				div_d     = 20'({1'b0, rd_q.visits} + 17'd1);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign mem_we    = (state_q == ST_MWT) && !div_busy;
	assign mem_waddr = ci9[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= '{mean: mean_new, value: ent_q.value,
				visits: ent_q.visits, prior: ent_q.prior};
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			child_count_q  <= CHILD_COUNT_RST;
			loss_step_q    <= LOSS_STEP_RST;
			explore_init_q <= EXPLORE_INIT_RST;
			explore_base_q <= EXPLORE_BASE_RST;
		end else if (wr_en) begin
			case (wr_addr)
				REG_CHILD_COUNT:  child_count_q  <= wr_data[6:0];
				REG_LOSS_STEP:    loss_step_q    <= wr_data[15:0];
				REG_EXPLORE_INIT: explore_init_q <= wr_data[15:0];
				REG_EXPLORE_BASE: explore_base_q <= wr_data;
				default:          child_count_q  <= child_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			parent_q    <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						case (s_tuser)
							KIND_LOAD: begin
								parent_q <= s_tdata[93:70];
								state_q  <= in_ok ? ST_MST : ST_FIN;
							end
							KIND_APPLY, KIND_REVERT: begin
								state_q <= in_ok ? ST_RD : ST_FIN;
							end
							default: begin
								state_q <= ST_SST;
							end
						endcase
					end
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					if (kind_q == KIND_APPLY) begin
						if (parent_q != PARENT_MAX) parent_q <= parent_q + 24'd1;
					end else begin
						if (parent_q != 24'd0) parent_q <= parent_q - 24'd1;
					end
					state_q <= ST_MST;
				end
				ST_MST: state_q <= ST_MWT;
				ST_MWT: begin
					if (!div_busy) state_q <= ST_FIN;
				end
				ST_SST: state_q <= ST_SW;
				ST_SW: begin
					if (!div_busy && !sq_busy) state_q <= ST_LOG;
				end
				ST_LOG: begin
					if (r_q[40:17] == 24'd0) state_q <= ST_LN;
				end
				ST_LN:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SRD;
				ST_SRD: state_q <= (cnt_q == scan_n) ? ST_FIN : ST_SPR;
				ST_SPR: state_q <= ST_SDS;
				ST_SDS: state_q <= ST_SDW;
				ST_SDW: begin
					if (!div_busy) begin
						if (!found_q || score > best_score_q) begin
							found_q <= 1'b1;
						end
						cnt_q   <= cnt_q + 7'd1;
						state_q <= ST_SRD;
					end
				end
				ST_FIN: begin
					if (fin_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q       <= s_tuser;
					ci_q         <= in_ci;
					ent_q.prior  <= s_tdata[21:6];
					ent_q.value  <= s_tdata[53:22];
					ent_q.visits <= s_tdata[69:54];
					ent_q.mean   <= '0;
					best_q       <= '0;
				end
			end
			ST_UPD: begin
				ent_q.prior <= rd_q.prior;
				ent_q.value <= vclamp;
				if (kind_q == KIND_APPLY) begin
					ent_q.visits <= (rd_q.visits != VISIT_MAX) ?
						rd_q.visits + 16'd1 : rd_q.visits;
				end else begin
					ent_q.visits <= (rd_q.visits != 16'd0) ?
						rd_q.visits - 16'd1 : rd_q.visits;
				end
			end
			ST_SW: begin
				r_q <= div_q;
				k_q <= '0;
			end
			ST_LOG: begin
				if (r_q[40:17] != 24'd0) begin
					r_q <= {1'b0, r_q[40:1]};
					k_q <= k_q + 5'd1;
				end
			end
			ST_LN:  c_q   <= 25'(ln_val) + {1'b0, explore_init_q, 8'b0};
			ST_MUL: csq_q <= c_q * sq_root;
			ST_SPR: t_q   <= csq_q * rd_q.prior;
			ST_SDW: begin
				if (!div_busy && (!found_q || score > best_score_q)) begin
					best_score_q <= score;
					best_q       <= cnt_q[5:0];
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					out_best_q   <= best_q;
					out_found_q  <= found_q;
					out_parent_q <= parent_q;
				end
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, out_parent_q, out_best_q};
	assign m_tuser  = out_found_q;

endmodule

### rtl/puct_div.sv
module puct_div
	import puct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              busy,
	output logic [DIV_NW-1:0] quotient
);

	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [DIV_DW+1:0] trial;

	assign trial = {1'b0, rem_q, q_q[DIV_NW-1]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DIV_NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_DW+1]) begin
				rem_q <= trial[DIV_DW-1:0];
				q_q   <= {q_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_DW-2:0], q_q[DIV_NW-1]};
				q_q   <= {q_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;

endmodule

### rtl/puct_sqrt.sv
module puct_sqrt
	import puct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_XW-1:0] radicand,
	output logic             busy,
	output logic [SQ_RW-1:0] root
);

	logic [SQ_XW-1:0] x_q;
	logic [SQ_RW:0]   rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [SQ_RW+2:0] r2;
	logic [SQ_RW+2:0] trial;
	logic [SQ_RW+2:0] diff;

	assign r2    = {rem_q, x_q[SQ_XW-1:SQ_XW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = r2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(SQ_RW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 5'd1;
			busy_q <= (cnt_q != 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[SQ_XW-3:0], 2'b00};
			if (r2 >= trial) begin
				rem_q  <= diff[SQ_RW:0];
				root_q <= {root_q[SQ_RW-2:0], 1'b1};
			end else begin
				rem_q  <= r2[SQ_RW:0];
				root_q <= {root_q[SQ_RW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule
